### rtl/apk_pkg.sv
// ----------------------------------------------------------------------------
// Atlas shelf packer package
// Shared constants and channel payload types of the shelf packer.
// ----------------------------------------------------------------------------
package apk_pkg;

	// Default sizes.
	localparam int DEF_MAX_SHELVES   = 64;
	localparam int DEF_MAX_SIZE_LOG2 = 13;

	// Smallest and reset side lengths, as log2 values.
	localparam logic [3:0] MIN_SIZE_LOG2   = 4'd4;
	localparam logic [3:0] RESET_SIZE_LOG2 = 4'd9;

	// Fixed field widths of the channels.
	localparam int DIM_W = 13;
	localparam int TOP_W = 14;
	localparam int LOG_W = 4;

	// One placement request.
	typedef struct packed {
		logic [DIM_W-1:0] glyph_width;
		logic [DIM_W-1:0] glyph_height;
		logic [DIM_W-1:0] shelf_height;
	} req_t;

	// One placement result.
	typedef struct packed {
		logic [DIM_W-1:0] left_x;
		logic [DIM_W-1:0] bottom_y;
		logic [TOP_W-1:0] top_y;
		logic [LOG_W-1:0] atlas_size_log2;
		logic             atlas_grew;
		logic             full_res;
	} res_t;

	// Commands broadcast from the controller to every shelf cell.
	typedef struct packed {
		logic decide;   // one placement try is evaluated this cycle
		logic alloc;    // a new shelf opens at the cell indexed by the count
	} cell_ctl_t;

endpackage

### rtl/apk_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one glyph placement request.
// ----------------------------------------------------------------------------
interface apk_req_if
	import apk_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/apk_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one glyph placement result.
// ----------------------------------------------------------------------------
interface apk_res_if
	import apk_pkg::*;
();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/apk_cell.sv
// ----------------------------------------------------------------------------
// Shelf cell
// Holds one shelf, tests it against the current request and passes the
// first-fit claim and the selected corner on to its neighbor.
// ----------------------------------------------------------------------------
module apk_cell
	import apk_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CNT_W = 7,
	parameter int POS_W = 14,
	parameter int SUM_W = 15
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [CNT_W-1:0]   shelf_count,
	input  logic [DIM_W-1:0]   glyph_width,
	input  logic [DIM_W-1:0]   shelf_height,
	input  logic [POS_W-1:0]   side,
	input  logic [POS_W-1:0]   next_base,
	input  logic               claim_in,
	input  logic [2*POS_W-1:0] data_in,
	output logic               claim_out,
	output logic [2*POS_W-1:0] data_out
);

	logic [POS_W-1:0] base_q;
	logic [DIM_W-1:0] tall_q;
	logic [POS_W-1:0] used_q;
	logic [POS_W-1:0] left_q;
	logic             sel_q;
	logic             open;
	logic             hit;
	logic             take;
	logic [SUM_W-1:0] reach;

	// The shelf fits when it is tall enough and the glyph ends short of the side.
	assign open  = shelf_count > CNT_W'(IDX);
	assign reach = SUM_W'(used_q) + SUM_W'(glyph_width);
	assign hit   = open && (tall_q >= shelf_height) && (reach < SUM_W'(side));

	// The first fitting cell in the row takes the glyph.
	assign take      = hit && !claim_in;
	assign claim_out = claim_in || hit;

	// The selected cell merges its corner into the collected result.
	assign data_out = data_in | (sel_q ? {left_q, base_q} : {(2*POS_W){1'b0}});

	// Selection flag, renewed at every try.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (ctl.decide) begin
			sel_q <= take;
		end
	end

	// Shelf contents: placement in this shelf or opening of this shelf.
	always_ff @(posedge clk) begin
		if (ctl.decide && take) begin
			left_q <= used_q;
			used_q <= POS_W'(reach);
		end else if (ctl.alloc && (shelf_count == CNT_W'(IDX))) begin
			base_q <= next_base;
			tall_q <= shelf_height;
			used_q <= POS_W'(glyph_width);
		end
	end

endmodule

### rtl/atlas_shelf_packer.sv
// ----------------------------------------------------------------------------
// Atlas shelf packer
// Search: after a request transfer the packer makes one try per cycle and
//   doubles the atlas (0 to 9 times) until the glyph is placed or is full.
// Overlap: a new request is taken while the previous result waits in the
//   output register. A blocked result register holds the packer in its
//   last step.
// Reset: no shelves, atlas side 2^9, initial size register 9. A register
//   write drops every shelf and sets the atlas to the clamped written size.
// ----------------------------------------------------------------------------
module atlas_shelf_packer
	import apk_pkg::*;
#(
	parameter int MAX_SHELVES   = DEF_MAX_SHELVES,
	parameter int MAX_SIZE_LOG2 = DEF_MAX_SIZE_LOG2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LOG_W-1:0] cfg_wdata,
	apk_req_if.sink          req,
	apk_res_if.source        res
);

	localparam int POS_W = MAX_SIZE_LOG2 + 1;
	localparam int SUM_W = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;
	localparam int CNT_W = $clog2(MAX_SHELVES + 1);
	localparam logic [LOG_W-1:0] MAX_LOG2 = LOG_W'(MAX_SIZE_LOG2);
	localparam logic [LOG_W-1:0] RST_LOG2 =
		(RESET_SIZE_LOG2 > MAX_LOG2) ? MAX_LOG2 : RESET_SIZE_LOG2;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_FIN    = 2'd2;

	logic [1:0]         state_q;
	logic [LOG_W-1:0]   atlas_q;
	logic [CNT_W-1:0]   count_q;
	logic [POS_W-1:0]   nsb_q;
	logic [DIM_W-1:0]   w_q;
	logic [DIM_W-1:0]   h_q;
	logic [DIM_W-1:0]   sh_q;
	logic               grew_q;
	logic               hit_q;
	logic               full_q;
	logic [POS_W-1:0]   pbase_q;
	logic               out_valid_q;
	res_t               out_q;

	logic [LOG_W-1:0]   cfg_log2;
	logic [POS_W-1:0]   side;
	logic [SUM_W-1:0]   nsb_end;
	logic               alloc_ok;
	logic               any_hit;
	logic               out_free;
	logic [POS_W-1:0]   fin_left;
	logic [POS_W-1:0]   fin_base;
	logic [SUM_W-1:0]   fin_top;
	cell_ctl_t          ctl;
	logic               claim [MAX_SHELVES+1];
	logic [2*POS_W-1:0] cdata [MAX_SHELVES+1];

	// Written size, clamped to the supported range.
	always_comb begin
		if (cfg_wdata < MIN_SIZE_LOG2) begin
			cfg_log2 = MIN_SIZE_LOG2;
		end else if (cfg_wdata > MAX_LOG2) begin
			cfg_log2 = MAX_LOG2;
		end else begin
			cfg_log2 = cfg_wdata;
		end
	end

	// New shelf test at the current side.
	assign side     = POS_W'(1) << atlas_q;
	assign nsb_end  = SUM_W'(nsb_q) + SUM_W'(sh_q);
	assign alloc_ok = (SUM_W'(w_q) < SUM_W'(side))
		&& (count_q < CNT_W'(MAX_SHELVES))
		&& (nsb_end <= SUM_W'(side));

	assign any_hit   = claim[MAX_SHELVES];
	assign ctl.decide = (state_q == ST_SEARCH);
	assign ctl.alloc  = (state_q == ST_SEARCH) && !any_hit && alloc_ok;

	// Row of shelf cells linked by the claim and result chains.
	assign claim[0] = 1'b0;
	assign cdata[0] = '0;
	for (genvar i = 0; i < MAX_SHELVES; i++) begin : g_cell
		apk_cell #(
			.IDX   (i),
			.CNT_W (CNT_W),
			.POS_W (POS_W),
			.SUM_W (SUM_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.shelf_count  (count_q),
			.glyph_width  (w_q),
			.shelf_height (sh_q),
			.side         (side),
			.next_base    (nsb_q),
			.claim_in     (claim[i]),
			.data_in      (cdata[i]),
			.claim_out    (claim[i+1]),
			.data_out     (cdata[i+1])
		);
	end

	// Final corner: from the selected cell, from a new shelf, or zero when full.
	always_comb begin
		if (full_q) begin
			fin_left = '0;
			fin_base = '0;
		end else if (hit_q) begin
			fin_left = cdata[MAX_SHELVES][2*POS_W-1:POS_W];
			fin_base = cdata[MAX_SHELVES][POS_W-1:0];
		end else begin
			fin_left = '0;
			fin_base = pbase_q;
		end
	end
	assign fin_top  = full_q ? '0 : (SUM_W'(fin_base) + SUM_W'(h_q));
	assign out_free = !out_valid_q || res.ready;

	// Sequencer: one try per cycle, atlas doubling between tries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			atlas_q <= RST_LOG2;
			count_q <= '0;
			nsb_q   <= '0;
			grew_q  <= 1'b0;
			hit_q   <= 1'b0;
			full_q  <= 1'b0;
		end else if (cfg_we) begin
			atlas_q <= cfg_log2;
			count_q <= '0;
			nsb_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						grew_q  <= 1'b0;
						hit_q   <= 1'b0;
						full_q  <= 1'b0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (any_hit) begin
						hit_q   <= 1'b1;
						state_q <= ST_FIN;
					end else if (alloc_ok) begin
						count_q <= count_q + 1'b1;
						nsb_q   <= POS_W'(nsb_end);
						state_q <= ST_FIN;
					end else if (atlas_q < MAX_LOG2) begin
						atlas_q <= atlas_q + 1'b1;
						grew_q  <= 1'b1;
					end else begin
						full_q  <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and base of a newly opened shelf.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			w_q  <= req.data.glyph_width;
			h_q  <= req.data.glyph_height;
			sh_q <= req.data.shelf_height;
		end
		if (ctl.alloc) begin
			pbase_q <= nsb_q;
		end
	end

	// Output register; a result leaves on a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_q.left_x          <= DIM_W'(fin_left);
			out_q.bottom_y        <= DIM_W'(fin_base);
			out_q.top_y           <= TOP_W'(fin_top);
			out_q.atlas_size_log2 <= atlas_q;
			out_q.atlas_grew      <= grew_q;
			out_q.full_res        <= full_q;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	// The atlas side stays within the supported range.
	a_atlas_range: assert property (@(posedge clk) disable iff (!arst_n)
		(atlas_q >= MIN_SIZE_LOG2) && (atlas_q <= MAX_LOG2))
		else $error("atlas size out of range");

	// The atlas never shrinks while a request is being placed.
	a_atlas_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) && !cfg_we |=> atlas_q >= $past(atlas_q))
		else $error("atlas shrank during a search");

	// The shelf count never passes the number of cells.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SHELVES))
		else $error("shelf count beyond cell row");

	// Open shelves never reach above the atlas top.
	a_nsb_side: assert property (@(posedge clk) disable iff (!arst_n)
		nsb_q <= side)
		else $error("shelf stack above atlas side");

	// A full result carries a zero left edge and a zero top.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.full_res |-> (out_q.left_x == '0) && (out_q.top_y == '0))
		else $error("full result with nonzero position");

endmodule

### verif/tb_atlas_shelf_packer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Atlas shelf packer testbench
// The testbench drives glyph placement requests into the packer and compares
// every result with a behavioral model of shelf first-fit packing or with a
// typed result. A table of directed requests comes first. Random phases follow,
// each starting with a new initial atlas size. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_atlas_shelf_packer
	import apk_pkg::*;
();

	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 24;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 190;
	localparam int PLAN_LEN     = 24;

	// Kinds of rows in the directed table.
	typedef enum logic [1:0] {
		ROW_PLACE,      // placement checked against the model
		ROW_PLACE_CHK,  // placement with the result typed in
		ROW_SIZE        // write of the initial size register
	} row_kind_e;

	typedef struct packed {
		row_kind_e  kind;
		req_t       glyph;
		res_t       want;
		logic [3:0] size;
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [LOG_W-1:0] cfg_wdata;

	apk_req_if req_ch ();
	apk_res_if res_ch ();

	atlas_shelf_packer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	// Model state: one entry per open shelf, plus the atlas size.
	logic [13:0] row_base [DEF_MAX_SHELVES];
	logic [12:0] row_tall [DEF_MAX_SHELVES];
	logic [13:0] row_fill [DEF_MAX_SHELVES];
	int          row_count;
	logic [13:0] row_next;
	logic [3:0]  cur_log2;
	logic [3:0]  boot_log2;

	res_t placements_due [$];
	int   errors = 0;
	int   cycles = 0;
	int   src_gap_pct = 20;
	int   sink_stall_pct = 20;

	// Directed requests. Typed results follow from the packer rules directly.
	row_t plan [PLAN_LEN] = '{
		// Reset size 512: the first glyph opens shelf 0.
		'{ROW_PLACE_CHK, '{13'd1, 13'd1, 13'd1},
			'{13'd0, 13'd0, 14'd1, 4'd9, 1'b0, 1'b0}, 4'd0},
		// Largest glyph: the atlas doubles up to the maximum side.
		'{ROW_PLACE_CHK, '{13'd8191, 13'd8191, 13'd8191},
			'{13'd0, 13'd1, 14'd8192, 4'd13, 1'b1, 1'b0}, 4'd0},
		'{ROW_PLACE_CHK, '{13'd1, 13'd1, 13'd1},
			'{13'd1, 13'd0, 14'd1, 4'd13, 1'b0, 1'b0}, 4'd0},
		'{ROW_PLACE, '{13'd8191, 13'd0, 13'd8191}, '0, 4'd0},
		// Nothing fits at the largest side.
		'{ROW_PLACE_CHK, '{13'd8191, 13'd8191, 13'd8191},
			'{13'd0, 13'd0, 14'd0, 4'd13, 1'b0, 1'b1}, 4'd0},
		'{ROW_PLACE_CHK, '{13'd8191, 13'd1, 13'd1},
			'{13'd0, 13'd0, 14'd0, 4'd13, 1'b0, 1'b1}, 4'd0},
		// A zero-height shelf opens at the very top of the atlas.
		'{ROW_PLACE, '{13'd8191, 13'd9, 13'd0}, '0, 4'd0},
		'{ROW_PLACE, '{13'd0, 13'd0, 13'd0}, '0, 4'd0},
		// Size below the minimum is raised to 16 pixels.
		'{ROW_SIZE, '0, '0, 4'd0},
		// Glyph as wide as the atlas: the atlas grows before a shelf opens.
		'{ROW_PLACE_CHK, '{13'd16, 13'd5, 13'd5},
			'{13'd0, 13'd0, 14'd5, 4'd5, 1'b1, 1'b0}, 4'd0},
		'{ROW_PLACE, '{13'd15, 13'd3, 13'd3}, '0, 4'd0},
		'{ROW_PLACE, '{13'd1, 13'd0, 13'd40}, '0, 4'd0},
		// Size above the maximum is lowered to the maximum.
		'{ROW_SIZE, '0, '0, 4'd15},
		'{ROW_PLACE, '{13'd8191, 13'd8191, 13'd0}, '0, 4'd0},
		'{ROW_PLACE, '{13'd0, 13'd1, 13'd0}, '0, 4'd0},
		'{ROW_PLACE, '{13'd1, 13'd1, 13'd0}, '0, 4'd0},
		'{ROW_SIZE, '0, '0, 4'd3},
		'{ROW_PLACE, '{13'd0, 13'd0, 13'd16}, '0, 4'd0},
		'{ROW_PLACE, '{13'd15, 13'd8191, 13'd17}, '0, 4'd0},
		'{ROW_SIZE, '0, '0, 4'd13},
		'{ROW_PLACE, '{13'd4096, 13'd4095, 13'd4096}, '0, 4'd0},
		'{ROW_PLACE, '{13'd2730, 13'd5461, 13'd1}, '0, 4'd0},
		'{ROW_SIZE, '0, '0, 4'd4},
		'{ROW_PLACE, '{13'd1, 13'd1, 13'd1}, '0, 4'd0}
	};

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Load a new initial size and drop every shelf, as a register write does.
	function automatic void load_size(input logic [3:0] value);
		if (value < MIN_SIZE_LOG2) begin
			boot_log2 = MIN_SIZE_LOG2;
		end else if (value > DEF_MAX_SIZE_LOG2) begin
			boot_log2 = 4'(DEF_MAX_SIZE_LOG2);
		end else begin
			boot_log2 = value;
		end
		row_count = 0;
		row_next  = '0;
		cur_log2  = boot_log2;
	endfunction

	// Place one glyph by shelf first fit and return the expected result.
	function automatic res_t place_glyph(input req_t glyph);
		res_t        o;
		int          side;
		int          slot;
		bit          placed;
		bit          grew;
		bit          done;
		logic [13:0] left;
		logic [13:0] bottom;
		placed = 1'b0;
		grew   = 1'b0;
		done   = 1'b0;
		slot   = 0;
		while (!done) begin
			side = 1 << cur_log2;
			// First shelf, in creation order, that is tall and has room enough.
			for (int i = 0; i < row_count; i++) begin
				if (!placed && row_tall[i] >= glyph.shelf_height &&
					int'(row_fill[i]) + int'(glyph.glyph_width) < side) begin
					placed = 1'b1;
					slot   = i;
				end
			end
			// Otherwise open a new shelf if the glyph fits across and above.
			if (!placed && int'(glyph.glyph_width) < side && row_count < DEF_MAX_SHELVES &&
				int'(row_next) + int'(glyph.shelf_height) <= side) begin
				slot           = row_count;
				row_base[slot] = row_next;
				row_tall[slot] = glyph.shelf_height;
				row_fill[slot] = '0;
				row_count++;
				row_next = row_next + glyph.shelf_height;
				placed   = 1'b1;
			end
			// Otherwise double the atlas, unless it is at its largest.
			if (placed || cur_log2 >= DEF_MAX_SIZE_LOG2) begin
				done = 1'b1;
			end else begin
				cur_log2 = cur_log2 + 4'd1;
				grew     = 1'b1;
			end
		end
		o = '0;
		if (placed) begin
			left           = row_fill[slot];
			bottom         = row_base[slot];
			row_fill[slot] = left + glyph.glyph_width;
			o.left_x       = left[12:0];
			o.bottom_y     = bottom[12:0];
			o.top_y        = 14'(bottom + glyph.glyph_height);
		end else begin
			o.full_res = 1'b1;
		end
		o.atlas_size_log2 = cur_log2;
		o.atlas_grew      = grew;
		return o;
	endfunction

	// Random request shaped by the current atlas side. Wide strips open many
	// shelves and fill the shelf table; the rest are small glyphs and noise.
	function automatic req_t make_glyph(input int strip_pct);
		req_t glyph;
		int   side;
		int   pick;
		side = 1 << cur_log2;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			glyph.glyph_width  = 13'($urandom_range(0, 8191));
			glyph.glyph_height = 13'($urandom_range(0, 8191));
			glyph.shelf_height = 13'($urandom_range(0, 8191));
		end else if (pick < 10 + strip_pct) begin
			glyph.glyph_width  = 13'($urandom_range(side / 2, side - 1));
			glyph.glyph_height = 13'($urandom_range(0, 63));
			glyph.shelf_height = 13'($urandom_range(0, 3));
		end else begin
			glyph.glyph_width  = 13'($urandom_range(0, side / 4));
			glyph.glyph_height = 13'($urandom_range(0, 255));
			glyph.shelf_height = 13'($urandom_range(0, 24));
		end
		return glyph;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Offer one request, wait for its transfer and record the expected result.
	task automatic offer_glyph(input req_t glyph, input bit typed, input res_t typed_res);
		int   gap;
		res_t predicted;
		if ($urandom_range(0, 99) < src_gap_pct) begin
			gap = $urandom_range(1, 12);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= glyph;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = place_glyph(glyph);
		placements_due.push_back(typed ? typed_res : predicted);
	endtask

	// Write the size register once every result has come back.
	task automatic write_size(input logic [3:0] value);
		req_ch.valid <= 1'b0;
		while (placements_due.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		load_size(value);
	endtask

	// Request side: reset, directed table, then random phases.
	initial begin : stimulus
		int strip_pct;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		load_size(RESET_SIZE_LOG2);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_SIZE) begin
				write_size(plan[k].size);
			end else begin
				offer_glyph(plan[k].glyph, plan[k].kind == ROW_PLACE_CHK, plan[k].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			write_size(4'($urandom_range(0, 15)));
			strip_pct = 25 * $urandom_range(0, 3);
			// The last phase runs at full rate on both sides.
			if (ph == PHASES - 1) begin
				src_gap_pct    = 0;
				sink_stall_pct = 0;
			end else begin
				src_gap_pct    = 20 * $urandom_range(0, 2);
				sink_stall_pct = 20 * $urandom_range(0, 2);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				offer_glyph(make_glyph(strip_pct), 1'b0, '0);
			end
		end

		req_ch.valid <= 1'b0;
		while (placements_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Result side: ready drops in random stall bursts.
	initial begin : result_sink
		int stall;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < sink_stall_pct) begin
				res_ch.ready <= 1'b0;
				stall = $urandom_range(1, 12);
				repeat (stall - 1) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest expected placement.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (placements_due.size() == 0) begin
				$display("%0t: result expected none actual %p", $time, res_ch.data);
				errors++;
			end else begin
				want = placements_due.pop_front();
				check_field("left_x", want.left_x, res_ch.data.left_x);
				check_field("bottom_y", want.bottom_y, res_ch.data.bottom_y);
				check_field("top_y", want.top_y, res_ch.data.top_y);
				check_field("atlas_size_log2", want.atlas_size_log2,
					res_ch.data.atlas_size_log2);
				check_field("atlas_grew", want.atlas_grew, res_ch.data.atlas_grew);
				check_field("full_res", want.full_res, res_ch.data.full_res);
			end
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin : watchdog
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				placements_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

### filelist.f
rtl/apk_pkg.sv
rtl/apk_req_if.sv
rtl/apk_res_if.sv
rtl/apk_cell.sv
rtl/atlas_shelf_packer.sv
verif/tb_atlas_shelf_packer.sv
